// ===== rtl/mtcp_pkg.sv =====
// Package for the holding register server: sizes, codes, state and reply types.
`timescale 1ns / 1ps

package mtcp_pkg;

   // Register file size and derived widths
   localparam int NUM_REGS = 16;
   localparam int REG_AW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int CNT_W    = $clog2(NUM_REGS + 1);

   // Frame geometry
   localparam int HDR_LEN  = 12;
   localparam int HDR_AW   = $clog2(HDR_LEN);
   localparam int MIN_LEN  = 8;
   localparam int SEEN_W   = 4;
   localparam int IDX_W    = 6;

   // Reset contents of the register file: base plus index
   localparam logic [15:0] REG_BASE = 16'd100;

   // Function codes
   localparam logic [7:0] FUNC_READ  = 8'd3;
   localparam logic [7:0] FUNC_WRITE = 8'd6;
   localparam logic [7:0] EXC_FLAG   = 8'h80;

   // Exception codes
   localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'd1;
   localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'd2;
   localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'd3;

   // Reply lengths
   localparam logic [IDX_W-1:0] EXC_TOTAL  = IDX_W'(9);
   localparam logic [IDX_W-1:0] ECHO_TOTAL = IDX_W'(HDR_LEN);
   localparam logic [IDX_W-1:0] READ_BASE  = IDX_W'(9);
   localparam logic [7:0]       EXC_FOLLOW = 8'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SEND
   } state_type;

   typedef enum logic [1:0] {
      RPL_EXC,
      RPL_READ,
      RPL_ECHO
   } reply_type;

   // Register file access from the controller
   typedef struct packed {
      logic              we;
      logic [REG_AW-1:0] waddr;
      logic [15:0]       wdata;
      logic [REG_AW-1:0] raddr;
   } rf_req_type;

endpackage

// ===== rtl/modbus_tcp_holding_register_server.sv =====
// Top level: request frame capture, decode and response byte sequencer.
`timescale 1ns / 1ps

// Channel   Ports                                  Handshake
// request   req_rx_byte, req_frame_end             start & !busy
// response  rsp_tx_byte, rsp_tx_last              strobe, one byte per cycle
//
// Request bytes are taken one per cycle while busy is low.
// After the final byte of a frame of 8 or more bytes, busy rises through the decode
// state and the send state, which emits the response (9, 12 or 9 + 2*count bytes); the
// response byte stream comes from an output register.
// The register file read is registered and is issued one byte ahead.
// Synchronous reset restores all holding registers to 100 plus index; the receiver
// cannot stall, so the response burst runs without gaps.
module modbus_tcp_holding_register_server (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_end,
   output logic       strobe,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last
);

   mtcp_pkg::state_type                state_ff, state_in;
   logic [mtcp_pkg::SEEN_W-1:0]        seen_ff, seen_in;
   logic [mtcp_pkg::SEEN_W-1:0]        len_ff, len_in;
   logic [7:0]                         hdr_ff [mtcp_pkg::HDR_LEN];
   mtcp_pkg::reply_type                kind_ff, kind_in;
   logic [mtcp_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [mtcp_pkg::IDX_W-1:0]         total_ff, total_in;
   logic [7:0]                         follow_ff, follow_in;
   logic [7:0]                         b7_ff, b7_in;
   logic [7:0]                         b8_ff, b8_in;
   logic [mtcp_pkg::REG_AW-1:0]        base_ff, base_in;
   logic                               strobe_ff, strobe_in;
   logic [7:0]                         byte_ff, byte_in;
   logic                               last_ff, last_in;

   logic                               accept;
   logic [mtcp_pkg::SEEN_W-1:0]        seen_inc;
   logic [7:0]                         func;
   logic [15:0]                        start16;
   logic [15:0]                        cnt16;
   logic [16:0]                        end17;
   logic                               short_frame;
   logic [mtcp_pkg::IDX_W-1:0]         rd_off;
   logic [15:0]                        rd_data;
   mtcp_pkg::rf_req_type               rf_req;

   assign accept  = start && !busy;
   assign busy    = (state_ff != mtcp_pkg::ST_IDLE);
   assign strobe  = strobe_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_tx_last = last_ff;

   // Saturating byte count
   assign seen_inc = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;

   // Header fields for decode
   assign func        = hdr_ff[7];
   assign start16     = {hdr_ff[8], hdr_ff[9]};
   assign cnt16       = {hdr_ff[10], hdr_ff[11]};
   assign end17       = {1'b0, start16} + {1'b0, cnt16};
   assign short_frame = (len_ff < mtcp_pkg::SEEN_W'(mtcp_pkg::HDR_LEN));

   // Read address runs one byte ahead of the sequencer
   assign rd_off = (idx_ff - mtcp_pkg::IDX_W'(8)) >> 1;

   mtcp_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rf_req  (rf_req),
      .rd_data (rd_data)
   );

   // Next state, decode and byte selection
   always_comb begin
      state_in  = state_ff;
      seen_in   = seen_ff;
      len_in    = len_ff;
      kind_in   = kind_ff;
      idx_in    = idx_ff;
      total_in  = total_ff;
      follow_in = follow_ff;
      b7_in     = b7_ff;
      b8_in     = b8_ff;
      base_in   = base_ff;
      strobe_in = 1'b0;
      byte_in   = byte_ff;
      last_in   = 1'b0;

      rf_req.we    = 1'b0;
      rf_req.waddr = start16[mtcp_pkg::REG_AW-1:0];
      rf_req.wdata = cnt16;
      rf_req.raddr = base_ff + rd_off[mtcp_pkg::REG_AW-1:0];

      unique case (state_ff)
         mtcp_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_frame_end) begin
                  seen_in = '0;
                  len_in  = seen_inc;
                  if (seen_inc >= mtcp_pkg::SEEN_W'(mtcp_pkg::MIN_LEN)) begin
                     state_in = mtcp_pkg::ST_DECIDE;
                  end
               end else begin
                  seen_in = seen_inc;
               end
            end
         end

         mtcp_pkg::ST_DECIDE: begin
            // Default to an exception reply
            kind_in   = mtcp_pkg::RPL_EXC;
            total_in  = mtcp_pkg::EXC_TOTAL;
            follow_in = mtcp_pkg::EXC_FOLLOW;
            b7_in     = func | mtcp_pkg::EXC_FLAG;
            b8_in     = mtcp_pkg::EXC_ILLEGAL_FUNC;
            base_in   = start16[mtcp_pkg::REG_AW-1:0];
            idx_in    = '0;
            state_in  = mtcp_pkg::ST_SEND;
            priority if (func == mtcp_pkg::FUNC_READ) begin
               priority if (short_frame) begin
                  b8_in = mtcp_pkg::EXC_ILLEGAL_VALUE;
               end else if (cnt16 == 16'd0 || cnt16 > 16'(mtcp_pkg::NUM_REGS)
                            || end17 > 17'(mtcp_pkg::NUM_REGS)) begin
                  b8_in = mtcp_pkg::EXC_ILLEGAL_ADDR;
               end else begin
                  kind_in   = mtcp_pkg::RPL_READ;
                  total_in  = mtcp_pkg::READ_BASE + {cnt16[mtcp_pkg::IDX_W-2:0], 1'b0};
                  follow_in = 8'd3 + {cnt16[6:0], 1'b0};
                  b7_in     = func;
                  b8_in     = {cnt16[6:0], 1'b0};
               end
            end else if (func == mtcp_pkg::FUNC_WRITE) begin
               priority if (short_frame) begin
                  b8_in = mtcp_pkg::EXC_ILLEGAL_VALUE;
               end else if (start16 >= 16'(mtcp_pkg::NUM_REGS)) begin
                  b8_in = mtcp_pkg::EXC_ILLEGAL_ADDR;
               end else begin
                  kind_in   = mtcp_pkg::RPL_ECHO;
                  total_in  = mtcp_pkg::ECHO_TOTAL;
                  rf_req.we = 1'b1;
               end
            end else begin
               b8_in = mtcp_pkg::EXC_ILLEGAL_FUNC;
            end
         end

         mtcp_pkg::ST_SEND: begin
            strobe_in = 1'b1;
            last_in   = (idx_ff == total_ff - 1'b1);
            idx_in    = idx_ff + 1'b1;
            if (last_in) begin
               state_in = mtcp_pkg::ST_IDLE;
            end
            // Response byte for this position
            priority if (kind_ff == mtcp_pkg::RPL_ECHO || idx_ff < mtcp_pkg::IDX_W'(4)
                         || idx_ff == mtcp_pkg::IDX_W'(6)) begin
               byte_in = hdr_ff[idx_ff[mtcp_pkg::HDR_AW-1:0]];
            end else if (idx_ff == mtcp_pkg::IDX_W'(4)) begin
               byte_in = 8'd0;
            end else if (idx_ff == mtcp_pkg::IDX_W'(5)) begin
               byte_in = follow_ff;
            end else if (idx_ff == mtcp_pkg::IDX_W'(7)) begin
               byte_in = b7_ff;
            end else if (idx_ff == mtcp_pkg::IDX_W'(8)) begin
               byte_in = b8_ff;
            end else begin
               // Register data, high byte on odd positions
               byte_in = idx_ff[0] ? rd_data[15:8] : rd_data[7:0];
            end
         end

         default: begin
            state_in = mtcp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mtcp_pkg::ST_IDLE;
         seen_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seen_ff   <= seen_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers and header capture
   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      kind_ff   <= kind_in;
      idx_ff    <= idx_in;
      total_ff  <= total_in;
      follow_ff <= follow_in;
      b7_ff     <= b7_in;
      b8_ff     <= b8_in;
      base_ff   <= base_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      if (accept && seen_ff < mtcp_pkg::SEEN_W'(mtcp_pkg::HDR_LEN)) begin
         hdr_ff[seen_ff[mtcp_pkg::HDR_AW-1:0]] <= req_rx_byte;
      end
   end

endmodule

// ===== rtl/mtcp_regfile.sv =====
// Holding register file: synchronous memory with per-entry valid bits for reset values.
`timescale 1ns / 1ps

module mtcp_regfile (
   input  logic                    clock,
   input  logic                    reset,
   input  mtcp_pkg::rf_req_type    rf_req,
   output logic [15:0]             rd_data
);

   logic [15:0]               regs_mem [mtcp_pkg::NUM_REGS];
   logic [mtcp_pkg::NUM_REGS-1:0] vld_ff;
   logic [15:0]               mem_q_ff;
   logic                      vld_q_ff;
   logic [15:0]               def_q_ff;

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (rf_req.we) begin
         regs_mem[rf_req.waddr] <= rf_req.wdata;
      end
      mem_q_ff <= regs_mem[rf_req.raddr];
      def_q_ff <= mtcp_pkg::REG_BASE + 16'(rf_req.raddr);
   end

   // Valid bits: an unwritten entry reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         if (rf_req.we) begin
            vld_ff[rf_req.waddr] <= 1'b1;
         end
         vld_q_ff <= vld_ff[rf_req.raddr];
      end
   end

   assign rd_data = vld_q_ff ? mem_q_ff : def_q_ff;

endmodule
